// ----- sv/cag_pkg.sv -----
`timescale 1ns / 1ps

package cag_pkg;

   localparam int NUM_UNITS_DEF = 4;
   localparam int UNIT_W = 2;
   localparam int DATA_W = 16;

   // below this, the inverted step takes the subtract-side correction
   localparam logic [31:0] STEP_SUB_LIMIT = 32'h0000_7FFF;

   typedef enum logic [2:0] {
      CMD_WR_ADDR = 3'd0,
      CMD_WR_WRAP = 3'd1,
      CMD_WR_STEP = 3'd2,
      CMD_READ    = 3'd3,
      CMD_INC     = 3'd4,
      CMD_DEC     = 3'd5,
      CMD_ADD     = 3'd6,
      CMD_SUB     = 3'd7
   } cmd_type;

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_EXEC = 2'b10
   } state_type;

   typedef struct packed {
      logic [DATA_W-1:0] addr;
      logic [DATA_W-1:0] wrap;
      logic [DATA_W-1:0] step;
   } entry_type;

endpackage

// ----- sv/cag_if.sv -----
`timescale 1ns / 1ps

interface cag_req_if;
   logic                        valid;
   logic                        ready;
   logic [2:0]                  cmd;
   logic [cag_pkg::UNIT_W-1:0]  unit;
   logic [cag_pkg::UNIT_W-1:0]  step_select;
   logic [cag_pkg::DATA_W-1:0]  value;

   modport source (output valid, cmd, unit, step_select, value, input ready);
   modport sink (input valid, cmd, unit, step_select, value, output ready);
endinterface

interface cag_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [cag_pkg::DATA_W-1:0]        addr;
   logic [cag_pkg::DATA_W-1:0]        wrap_len;
   logic signed [cag_pkg::DATA_W-1:0] step;
   logic                              wrapped;

   modport source (output valid, addr, wrap_len, step, wrapped, input ready);
   modport sink (input valid, addr, wrap_len, step, wrapped, output ready);
endinterface

// ----- sv/cag_mem.sv -----
`timescale 1ns / 1ps

// Register-set memory: one write port, two registered read ports.
// Entries that were never written read as zero through per-entry valid bits.
module cag_mem #(
   parameter int NUM_UNITS = cag_pkg::NUM_UNITS_DEF,
   parameter int IDX_W = (NUM_UNITS > 1) ? $clog2(NUM_UNITS) : 1
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        rd_en,
   input  logic [IDX_W-1:0]            rd_idx_a,
   input  logic [IDX_W-1:0]            rd_idx_b,
   output cag_pkg::entry_type          rd_entry_a,
   output logic [cag_pkg::DATA_W-1:0]  rd_step_b,
   input  logic                        wr_en,
   input  logic [IDX_W-1:0]            wr_idx,
   input  cag_pkg::entry_type          wr_entry
);

   cag_pkg::entry_type          mem [NUM_UNITS];
   logic [NUM_UNITS-1:0]        valid_ff;
   cag_pkg::entry_type          rd_a_ff;
   logic [cag_pkg::DATA_W-1:0]  rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= wr_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_idx] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_a_ff <= valid_ff[rd_idx_a] ? mem[rd_idx_a] : '0;
         rd_b_ff <= valid_ff[rd_idx_b] ? mem[rd_idx_b].step : '0;
      end
   end

   assign rd_entry_a = rd_a_ff;
   assign rd_step_b  = rd_b_ff;

endmodule

// ----- sv/cag_alu.sv -----
`timescale 1ns / 1ps

// Modulo address update and register merge for one command.
module cag_alu (
   input  cag_pkg::cmd_type            cmd,
   input  logic [cag_pkg::DATA_W-1:0]  value,
   input  cag_pkg::entry_type          cur,
   input  logic [cag_pkg::DATA_W-1:0]  sel_step,
   output cag_pkg::entry_type          nxt,
   output logic                        wrapped
);

   always_comb begin
      logic [31:0] a;
      logic [31:0] w;
      logic [31:0] m;
      logic [31:0] n;
      logic [31:0] x;
      logic [31:0] d;
      logic [31:0] w1;
      logic        sub_side;

      a = {16'd0, cur.addr};
      w = {16'd0, cur.wrap};
      w1 = w + 32'd1;
      m = (w | 32'd1) << 1;
      x = '0;
      d = '0;
      n = a;
      sub_side = 1'b0;
      wrapped = 1'b0;
      nxt = cur;

      unique case (cmd)
         cag_pkg::CMD_WR_ADDR: nxt.addr = value;
         cag_pkg::CMD_WR_WRAP: nxt.wrap = value;
         cag_pkg::CMD_WR_STEP: nxt.step = value;
         cag_pkg::CMD_READ: ;
         cag_pkg::CMD_INC: begin
            n = a + 32'd1;
            if ((n ^ a) > m) begin
               n = n - w1;
               wrapped = 1'b1;
            end
            nxt.addr = n[15:0];
         end
         cag_pkg::CMD_DEC: begin
            n = a + w;
            if (((n ^ a) & m) > w) begin
               n = n - w1;
               wrapped = 1'b1;
            end
            nxt.addr = n[15:0];
         end
         cag_pkg::CMD_ADD, cag_pkg::CMD_SUB: begin
            if (cmd == cag_pkg::CMD_ADD) begin
               x = {{16{sel_step[15]}}, sel_step};
               n = a + x;
               sub_side = ~x[31];
            end else begin
               // subtract own step as add of inverted step plus carry in
               x = ~{{16{cur.step[15]}}, cur.step};
               n = a + x + 32'd1;
               sub_side = x < cag_pkg::STEP_SUB_LIMIT;
            end
            d = (n ^ a ^ x) & m;
            if (sub_side) begin
               if (d > w) begin
                  n = n - w1;
                  wrapped = 1'b1;
                end
            end else if ((((n + w1) ^ n) & d) <= w) begin
               n = n + w1;
               wrapped = 1'b1;
            end
            nxt.addr = n[15:0];
         end
         default: ;
      endcase
   end

endmodule

// ----- sv/circular_address_generator.sv -----
`timescale 1ns / 1ps
// Result: the memory is read on accept, then the execute state registers the update and raises valid.
// One item at a time: the register-set memory is read in the accept
//    cycle and written back in the execute cycle, with no overlap between items.
// A full output register holds the execute step until the result is taken.
// Reset: synchronous, clears control state and all valid bits; every unit's entry then reads zero.
module circular_address_generator #(
   parameter int NUM_UNITS = cag_pkg::NUM_UNITS_DEF
) (
   input  logic   clock,
   input  logic   reset,
   cag_req_if.sink   req_chan,
   cag_rsp_if.source rsp_chan
);

   localparam int IDX_W = (NUM_UNITS > 1) ? $clog2(NUM_UNITS) : 1;

   cag_pkg::state_type           state_ff, state_in;
   cag_pkg::cmd_type             cmd_ff;
   logic [cag_pkg::DATA_W-1:0]   value_ff;
   logic [IDX_W-1:0]             idx_ff;
   logic                         unit_ok_ff;
   logic                         sel_ok_ff;

   logic                         rsp_valid_ff, rsp_valid_in;
   cag_pkg::entry_type           rsp_entry_ff;
   logic                         rsp_wrapped_ff;

   logic                         accept;
   logic                         finish;
   logic [IDX_W-1:0]             unit_idx;
   logic [IDX_W-1:0]             sel_idx;
   cag_pkg::entry_type           cur_entry;
   logic [cag_pkg::DATA_W-1:0]   sel_step_raw;
   logic [cag_pkg::DATA_W-1:0]   sel_step;
   cag_pkg::entry_type           nxt_entry;
   logic                         nxt_wrapped;

   assign req_chan.ready = (state_ff == cag_pkg::S_IDLE);
   assign accept = req_chan.valid && req_chan.ready;
   assign finish = (state_ff == cag_pkg::S_EXEC) && (!rsp_valid_ff || rsp_chan.ready);

   assign unit_idx = IDX_W'(req_chan.unit);
   assign sel_idx  = IDX_W'(req_chan.step_select);

   cag_mem #(
      .NUM_UNITS (NUM_UNITS),
      .IDX_W     (IDX_W)
   ) u_mem (
      .clock      (clock),
      .reset      (reset),
      .rd_en      (accept),
      .rd_idx_a   (unit_idx),
      .rd_idx_b   (sel_idx),
      .rd_entry_a (cur_entry),
      .rd_step_b  (sel_step_raw),
      .wr_en      (finish && unit_ok_ff),
      .wr_idx     (idx_ff),
      .wr_entry   (nxt_entry)
   );

   assign sel_step = sel_ok_ff ? sel_step_raw : '0;

   cag_alu u_alu (
      .cmd      (cmd_ff),
      .value    (value_ff),
      .cur      (cur_entry),
      .sel_step (sel_step),
      .nxt      (nxt_entry),
      .wrapped  (nxt_wrapped)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         cag_pkg::S_IDLE: begin
            if (accept) begin
               state_in = cag_pkg::S_EXEC;
            end
         end
         cag_pkg::S_EXEC: begin
            if (finish) begin
               state_in = cag_pkg::S_IDLE;
            end
         end
         default: state_in = cag_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cag_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff     <= cag_pkg::cmd_type'(req_chan.cmd);
         value_ff   <= req_chan.value;
         idx_ff     <= unit_idx;
         unit_ok_ff <= (int'(req_chan.unit) < NUM_UNITS);
         sel_ok_ff  <= (int'(req_chan.step_select) < NUM_UNITS);
      end
   end

   // out-of-range unit: no write, all-zero result
   always_ff @(posedge clock) begin
      if (finish) begin
         rsp_entry_ff   <= unit_ok_ff ? nxt_entry : '0;
         rsp_wrapped_ff <= unit_ok_ff && nxt_wrapped;
      end
   end

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.addr     = rsp_entry_ff.addr;
   assign rsp_chan.wrap_len = rsp_entry_ff.wrap;
   assign rsp_chan.step     = $signed(rsp_entry_ff.step);
   assign rsp_chan.wrapped  = rsp_wrapped_ff;

endmodule

// ----- bench/circular_address_generator_checker.sv -----
`timescale 1ns / 1ps

module circular_address_generator_checker #(
   parameter int NUM_UNITS = cag_pkg::NUM_UNITS_DEF
) (
   input  logic clock,
   input  logic reset,
   cag_req_if   req_mon,
   cag_rsp_if   rsp_mon,
   output int   fail_count,
   output int   outstanding
);

   typedef struct packed {
      logic [cag_pkg::DATA_W-1:0]        addr;
      logic [cag_pkg::DATA_W-1:0]        wrap_len;
      logic signed [cag_pkg::DATA_W-1:0] step;
      logic                              wrapped;
   } addr_result_type;

   logic [cag_pkg::DATA_W-1:0] addr_bank [NUM_UNITS];
   logic [cag_pkg::DATA_W-1:0] wrap_bank [NUM_UNITS];
   logic [cag_pkg::DATA_W-1:0] step_bank [NUM_UNITS];

   addr_result_type expected_results [$];
   addr_result_type oldest;

   function automatic logic [31:0] sign_extend(input logic [cag_pkg::DATA_W-1:0] v);
      return {{(32-cag_pkg::DATA_W){v[cag_pkg::DATA_W-1]}}, v};
   endfunction

   // n already holds a + x (+ carry); fix it up by wrap + 1 in either direction
   function automatic logic [31:0] apply_wrap(input logic [31:0] a, input logic [31:0] w,
                                              input logic [31:0] n, input logic [31:0] x,
                                              input bit below_side, output bit wrapped);
      logic [31:0] m;
      logic [31:0] d;
      m = (w | 32'd1) << 1;
      d = (n ^ a ^ x) & m;
      wrapped = 1'b0;
      if (below_side) begin
         if (d > w) begin
            n = n - w - 32'd1;
            wrapped = 1'b1;
         end
      end else if ((((n + w + 32'd1) ^ n) & d) <= w) begin
         n = n + w + 32'd1;
         wrapped = 1'b1;
      end
      return n;
   endfunction

   function automatic addr_result_type predict_update(
      input cag_pkg::cmd_type c,
      input logic [cag_pkg::UNIT_W-1:0] u,
      input logic [cag_pkg::UNIT_W-1:0] sel,
      input logic [cag_pkg::DATA_W-1:0] v
   );
      addr_result_type r;
      logic [31:0]  a;
      logic [31:0]  w;
      logic [31:0]  m;
      logic [31:0]  n;
      logic [31:0]  s;
      logic [31:0]  x;
      bit           wr;
      r = '0;
      wr = 1'b0;
      if (int'(u) >= NUM_UNITS)
         return r;
      a = {16'd0, addr_bank[u]};
      w = {16'd0, wrap_bank[u]};
      m = (w | 32'd1) << 1;
      n = a;
      case (c)
         cag_pkg::CMD_WR_ADDR: addr_bank[u] = v;
         cag_pkg::CMD_WR_WRAP: wrap_bank[u] = v;
         cag_pkg::CMD_WR_STEP: step_bank[u] = v;
         cag_pkg::CMD_INC: begin
            n = a + 32'd1;
            if ((n ^ a) > m) begin
               n = n - w - 32'd1;
               wr = 1'b1;
            end
            addr_bank[u] = n[cag_pkg::DATA_W-1:0];
         end
         cag_pkg::CMD_DEC: begin
            // the subtraction is the normal, in-range path here
            n = a + w;
            if (((n ^ a) & m) > w) begin
               n = n - w - 32'd1;
               wr = 1'b1;
            end
            addr_bank[u] = n[cag_pkg::DATA_W-1:0];
         end
         cag_pkg::CMD_ADD: begin
            s = (int'(sel) < NUM_UNITS) ? sign_extend(step_bank[sel]) : 32'd0;
            n = apply_wrap(a, w, a + s, s, !s[31], wr);
            addr_bank[u] = n[cag_pkg::DATA_W-1:0];
         end
         cag_pkg::CMD_SUB: begin
            // a step of -32768 lands on the add-side test
            x = ~sign_extend(step_bank[u]);
            n = apply_wrap(a, w, a + x + 32'd1, x, x < cag_pkg::STEP_SUB_LIMIT, wr);
            addr_bank[u] = n[cag_pkg::DATA_W-1:0];
         end
         default: ;
      endcase
      r.addr     = addr_bank[u];
      r.wrap_len = wrap_bank[u];
      r.step     = step_bank[u];
      r.wrapped  = wr;
      return r;
   endfunction

   task automatic check_field(input string name, input logic [cag_pkg::DATA_W-1:0] want_v,
                              input logic [cag_pkg::DATA_W-1:0] got_v);
      if (want_v !== got_v) begin
         $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want_v, got_v);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_UNITS; i++) begin
            addr_bank[i] = '0;
            wrap_bank[i] = '0;
            step_bank[i] = '0;
         end
         expected_results.delete();
         fail_count = 0;
         outstanding = 0;
      end else begin
         if (req_mon.valid && req_mon.ready)
            expected_results.push_back(predict_update(cag_pkg::cmd_type'(req_mon.cmd),
                                                      req_mon.unit, req_mon.step_select,
                                                      req_mon.value));
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_results.size() == 0) begin
               $display({"%0t: unexpected item: expected none, ",
                         "actual addr %h wrap %h step %h wrapped %b"},
                        $time, rsp_mon.addr, rsp_mon.wrap_len, rsp_mon.step, rsp_mon.wrapped);
               fail_count++;
            end else begin
               oldest = expected_results.pop_front();
               check_field("addr", oldest.addr, rsp_mon.addr);
               check_field("wrap_len", oldest.wrap_len, rsp_mon.wrap_len);
               check_field("step", oldest.step, rsp_mon.step);
               check_field("wrapped", {15'd0, oldest.wrapped}, {15'd0, rsp_mon.wrapped});
            end
         end
         outstanding = expected_results.size();
      end
   end

endmodule

// ----- bench/circular_address_generator_tb.sv -----
`timescale 1ns / 1ps

module circular_address_generator_tb;

   localparam int RANDOM_ITEMS = 1800;
   localparam int LONG_HOLD    = 300;
   localparam int CYCLE_LIMIT  = 400000;

   logic clock = 1'b0;
   logic reset;
   int   fail_count;
   int   outstanding;
   int   cycle_count = 0;
   bit   long_hold_pending = 1'b0;

   cag_req_if req_chan ();
   cag_rsp_if rsp_chan ();

   circular_address_generator dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   circular_address_generator_checker checker_inst (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_chan),
      .rsp_mon     (rsp_chan),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("circular_address_generator verification failed");
         $finish;
      end
   end

   task automatic offer_item(input cag_pkg::cmd_type c,
                             input logic [cag_pkg::UNIT_W-1:0] u,
                             input logic [cag_pkg::UNIT_W-1:0] sel,
                             input logic [cag_pkg::DATA_W-1:0] v);
      @(negedge clock);
      req_chan.valid       <= 1'b1;
      req_chan.cmd         <= c;
      req_chan.unit        <= u;
      req_chan.step_select <= sel;
      req_chan.value       <= v;
      @(posedge clock);
      while (!req_chan.ready)
         @(posedge clock);
   endtask

   // junk payload while valid is low
   task automatic idle_sender(input int n);
      if (n > 0) begin
         @(negedge clock);
         req_chan.valid       <= 1'b0;
         req_chan.cmd         <= 3'($urandom);
         req_chan.unit        <= cag_pkg::UNIT_W'($urandom);
         req_chan.step_select <= cag_pkg::UNIT_W'($urandom);
         req_chan.value       <= cag_pkg::DATA_W'($urandom);
         repeat (n - 1) @(negedge clock);
      end
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (outstanding != 0)
         @(negedge clock);
   endtask

   function automatic cag_pkg::cmd_type pick_command();
      int r;
      r = $urandom_range(0, 99);
      if (r < 8)       return cag_pkg::CMD_WR_ADDR;
      else if (r < 16) return cag_pkg::CMD_WR_WRAP;
      else if (r < 24) return cag_pkg::CMD_WR_STEP;
      else if (r < 30) return cag_pkg::CMD_READ;
      else if (r < 48) return cag_pkg::CMD_INC;
      else if (r < 64) return cag_pkg::CMD_DEC;
      else if (r < 82) return cag_pkg::CMD_ADD;
      else             return cag_pkg::CMD_SUB;
   endfunction

   // writes favor buffer-like setups: wrap of 2^k-1, small steps, boundary values
   function automatic logic [cag_pkg::DATA_W-1:0] pick_value(input cag_pkg::cmd_type c);
      int r;
      r = $urandom_range(0, 3);
      case (c)
         cag_pkg::CMD_WR_WRAP: begin
            if (r < 3) return cag_pkg::DATA_W'((32'd1 << $urandom_range(0, 16)) - 32'd1);
            else       return cag_pkg::DATA_W'($urandom);
         end
         cag_pkg::CMD_WR_STEP: begin
            if (r < 2) return cag_pkg::DATA_W'(int'($urandom_range(0, 40)) - 20);
            else if (r == 2) begin
               case ($urandom_range(0, 3))
                  0:       return 16'h7FFF;
                  1:       return 16'h8000;
                  2:       return 16'h8001;
                  default: return 16'hFFFF;
               endcase
            end
            else return cag_pkg::DATA_W'($urandom);
         end
         cag_pkg::CMD_WR_ADDR: begin
            if (r == 0)      return cag_pkg::DATA_W'($urandom_range(0, 31));
            else if (r == 1) return cag_pkg::DATA_W'(16'hFFFF - $urandom_range(0, 31));
            else             return cag_pkg::DATA_W'($urandom);
         end
         default: return cag_pkg::DATA_W'($urandom);
      endcase
   endfunction

   // receiver: shifting stall patterns, plus one long hold-off on request
   initial begin
      int stall_mode;
      int mode_left;
      stall_mode = 0;
      mode_left = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold_pending) begin
            rsp_chan.ready <= 1'b0;
            repeat (LONG_HOLD - 1) @(negedge clock);
            long_hold_pending = 1'b0;
         end else begin
            if (mode_left == 0) begin
               stall_mode = $urandom_range(0, 3);
               mode_left = $urandom_range(40, 200);
            end
            mode_left--;
            case (stall_mode)
               0:       rsp_chan.ready <= 1'b1;
               1:       rsp_chan.ready <= ($urandom_range(0, 1) == 1);
               2:       rsp_chan.ready <= ($urandom_range(0, 7) != 0);
               default: rsp_chan.ready <= ((cycle_count % 5) != 0);
            endcase
         end
      end
   end

   initial begin
      int burst_left;
      cag_pkg::cmd_type c;
      burst_left = 0;
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.cmd = cag_pkg::CMD_READ;
      req_chan.unit = '0;
      req_chan.step_select = '0;
      req_chan.value = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // state after reset
      offer_item(cag_pkg::CMD_READ, 2'd0, 2'd0, 16'h0000);
      offer_item(cag_pkg::CMD_READ, 2'd1, 2'd3, 16'hFFFF);
      offer_item(cag_pkg::CMD_READ, 2'd2, 2'd0, 16'h0000);
      offer_item(cag_pkg::CMD_READ, 2'd3, 2'd3, 16'hFFFF);
      // small buffer, wrap both ways
      offer_item(cag_pkg::CMD_WR_WRAP, 2'd0, 2'd0, 16'h0007);
      offer_item(cag_pkg::CMD_WR_ADDR, 2'd0, 2'd0, 16'h0007);
      offer_item(cag_pkg::CMD_INC, 2'd0, 2'd0, 16'h0000);
      offer_item(cag_pkg::CMD_DEC, 2'd0, 2'd0, 16'h0000);
      offer_item(cag_pkg::CMD_WR_STEP, 2'd0, 2'd0, 16'h0003);
      offer_item(cag_pkg::CMD_ADD, 2'd0, 2'd0, 16'h0000);
      offer_item(cag_pkg::CMD_SUB, 2'd0, 2'd0, 16'h0000);
      offer_item(cag_pkg::CMD_WR_STEP, 2'd0, 2'd0, 16'hFFFD);
      offer_item(cag_pkg::CMD_ADD, 2'd0, 2'd0, 16'h0000);
      offer_item(cag_pkg::CMD_SUB, 2'd0, 2'd0, 16'h0000);
      // full-range buffer with extreme steps, -32768 subtracted
      offer_item(cag_pkg::CMD_WR_WRAP, 2'd1, 2'd0, 16'hFFFF);
      offer_item(cag_pkg::CMD_WR_ADDR, 2'd1, 2'd0, 16'hFFFF);
      offer_item(cag_pkg::CMD_INC, 2'd1, 2'd0, 16'h0000);
      offer_item(cag_pkg::CMD_DEC, 2'd1, 2'd0, 16'h0000);
      offer_item(cag_pkg::CMD_WR_STEP, 2'd1, 2'd0, 16'h8000);
      offer_item(cag_pkg::CMD_SUB, 2'd1, 2'd0, 16'h0000);
      offer_item(cag_pkg::CMD_WR_STEP, 2'd1, 2'd0, 16'h7FFF);
      offer_item(cag_pkg::CMD_ADD, 2'd1, 2'd1, 16'h0000);
      // zero wrap, step taken from another unit
      offer_item(cag_pkg::CMD_WR_WRAP, 2'd2, 2'd0, 16'h0000);
      offer_item(cag_pkg::CMD_WR_ADDR, 2'd2, 2'd0, 16'h0000);
      offer_item(cag_pkg::CMD_ADD, 2'd2, 2'd1, 16'h0000);
      offer_item(cag_pkg::CMD_SUB, 2'd2, 2'd0, 16'h0000);
      drain_results();

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == 200)
            long_hold_pending = 1'b1;
         if (i % 450 == 449)
            drain_results();
         if (burst_left == 0) begin
            idle_sender(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8));
            burst_left = $urandom_range(1, 16);
         end
         burst_left--;
         c = pick_command();
         offer_item(c, cag_pkg::UNIT_W'($urandom), cag_pkg::UNIT_W'($urandom), pick_value(c));
      end

      drain_results();
      repeat (16) @(negedge clock);
      if (fail_count == 0 && outstanding == 0)
         $display("circular_address_generator verification clean");
      else
         $display("circular_address_generator verification failed");
      $finish;
   end

endmodule
